[sv/edf_pkg.sv]
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and widths for the earliest-deadline-first tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

    localparam int MAX_TASKS   = 16;
    localparam int IDX_W       = 4;
    localparam int SLOT_W      = 3;
    localparam int TIME_W      = 16;
    localparam int DL_W        = 17;
    localparam int TCNT_W      = 4;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 8;

    localparam logic signed [DL_W-1:0] DL_MIN = {1'b1, {(DL_W-1){1'b0}}};

    localparam logic [TCNT_W-1:0] TCNT_RESET = 4'd8;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_TICK = 1'b1
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [SLOT_W-1:0]  slot;
        logic [TIME_W-1:0]  compute_time;
        logic [TIME_W-1:0]  period;
        logic [TIME_W-1:0]  relative_deadline;
    } t_item;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
    } t_pick;

endpackage

`default_nettype wire

[sv/edf_pick.sv]
// ----------------------------------------------------------------------------
// edf_pick
// Compare tree that finds the ready slot with the least time to deadline,
// lowest slot first on a tie.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_pick #(
    parameter int TASKS = 8
) (
    input  wire logic [TASKS-1:0]               i_ready,
    input  wire logic signed [edf_pkg::DL_W-1:0] i_key [TASKS],
    output edf_pkg::t_pick                       o_pick
);
    import edf_pkg::*;

    localparam int LEVELS = (TASKS > 1) ? $clog2(TASKS) : 0;
    localparam int LEAVES = 1 << LEVELS;
    localparam int NODES  = 2 * LEAVES - 1;

    logic                    nd_valid [NODES];
    logic signed [DL_W-1:0]  nd_key   [NODES];
    logic [IDX_W-1:0]        nd_idx   [NODES];

    genvar j, k;

    // leaves
    for (j = 0; j < LEAVES; j++) begin : g_leaf
        if (j < TASKS) begin : g_used
            assign nd_valid[LEAVES-1+j] = i_ready[j];
            assign nd_key[LEAVES-1+j]   = i_key[j];
        end else begin : g_pad
            assign nd_valid[LEAVES-1+j] = 1'b0;
            assign nd_key[LEAVES-1+j]   = '0;
        end
        assign nd_idx[LEAVES-1+j] = IDX_W'(j);
    end

    // inner nodes, left child holds the lower slots
    for (k = 0; k < LEAVES - 1; k++) begin : g_node
        logic take_left;
        assign take_left = nd_valid[2*k+1] &&
                           (!nd_valid[2*k+2] || (nd_key[2*k+1] <= nd_key[2*k+2]));
        assign nd_valid[k] = nd_valid[2*k+1] || nd_valid[2*k+2];
        assign nd_key[k]   = take_left ? nd_key[2*k+1] : nd_key[2*k+2];
        assign nd_idx[k]   = take_left ? nd_idx[2*k+1] : nd_idx[2*k+2];
    end

    assign o_pick.found = nd_valid[0];
    assign o_pick.idx   = nd_idx[0];

endmodule

`default_nettype wire

[sv/edf_periodic_task_scheduler.sv]
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler
// Earliest-deadline-first tick scheduler for up to TASKS periodic tasks.
// ----------------------------------------------------------------------------
// Items enter an input register and are resolved once the output register
// can take the result: release of due tasks, the deadline compare tree over
// all slots and the per-slot countdown updates happen in that same cycle,
// and the answer is held in an output register. One item is taken per clock
// cycle unless m_axis_tready stalls the output; the compare tree in edf_pick
// is combinational. A load item answers idle, a tick item the slot that ran,
// or idle if none is ready. The user must write task_count through the
// configuration port only while no item is in flight; this is not enforced.
`default_nettype none

module edf_periodic_task_scheduler #(
    parameter int TASKS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [edf_pkg::TCNT_W-1:0]        i_cfg_wr_data,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // slot, compute_time, period, relative_deadline, zero fill
    input  wire logic [edf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action
    input  wire logic [0:0]                        s_axis_tuser,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // running_task, zero fill
    output      logic [edf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // idle
    output      logic [0:0]                        m_axis_tuser
);
    import edf_pkg::*;

    localparam int SEL_W = (TASKS > 1) ? $clog2(TASKS) : 1;

    // control and payload registers
    logic [TCNT_W-1:0]       r_task_count;
    logic                    r_in_valid;
    t_item                   r_in;
    logic                    r_out_valid;
    logic                    r_out_idle;
    logic [SLOT_W-1:0]       r_out_task;

    // task table and run state
    logic [TIME_W-1:0]       r_cmp  [TASKS];
    logic [TIME_W-1:0]       r_per  [TASKS];
    logic [TIME_W-1:0]       r_rdl  [TASKS];
    logic [TIME_W-1:0]       r_rem  [TASKS];
    logic [TIME_W-1:0]       r_cd   [TASKS];
    logic signed [DL_W-1:0]  r_dl   [TASKS];

    logic [TIME_W-1:0]       n_cmp  [TASKS];
    logic [TIME_W-1:0]       n_per  [TASKS];
    logic [TIME_W-1:0]       n_rdl  [TASKS];
    logic [TIME_W-1:0]       n_rem  [TASKS];
    logic [TIME_W-1:0]       n_cd   [TASKS];
    logic signed [DL_W-1:0]  n_dl   [TASKS];

    // post-release view
    logic [TASKS-1:0]        active;
    logic [TASKS-1:0]        release_now;
    logic [TASKS-1:0]        ready;
    logic [TIME_W-1:0]       rel_rem [TASKS];
    logic [TIME_W-1:0]       rel_cd  [TASKS];
    logic signed [DL_W-1:0]  rel_dl  [TASKS];

    t_pick                   pick;
    logic                    advance;
    logic                    process;
    logic                    is_tick;
    logic                    is_load;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign process       = r_in_valid && advance;
    assign is_tick       = process && (r_in.action == ACT_TICK);
    assign is_load       = process && (r_in.action == ACT_LOAD);

    always_comb begin
        for (int i = 0; i < TASKS; i++) begin
            active[i]      = int'(r_task_count) > i;
            release_now[i] = (r_per[i] != '0) && (r_cd[i] == '0);
            rel_rem[i]     = release_now[i] ? r_cmp[i] : r_rem[i];
            rel_cd[i]      = release_now[i] ? r_per[i] : r_cd[i];
            rel_dl[i]      = release_now[i] ? $signed({1'b0, r_rdl[i]}) : r_dl[i];
            ready[i]       = active[i] && (rel_rem[i] != '0);
        end
    end

    edf_pick #(
        .TASKS (TASKS)
    ) u_pick (
        .i_ready (ready),
        .i_key   (rel_dl),
        .o_pick  (pick)
    );

    always_comb begin
        for (int i = 0; i < TASKS; i++) begin
            n_cmp[i] = r_cmp[i];
            n_per[i] = r_per[i];
            n_rdl[i] = r_rdl[i];
            n_rem[i] = r_rem[i];
            n_cd[i]  = r_cd[i];
            n_dl[i]  = r_dl[i];
            if (is_load && (int'(r_in.slot) == i)) begin
                n_cmp[i] = r_in.compute_time;
                n_per[i] = r_in.period;
                n_rdl[i] = r_in.relative_deadline;
                n_rem[i] = '0;
                n_cd[i]  = '0;
                n_dl[i]  = '0;
            end else if (is_tick && active[i]) begin
                n_rem[i] = (pick.found && (int'(pick.idx) == i)) ?
                           rel_rem[i] - TIME_W'(1) : rel_rem[i];
                n_cd[i]  = ((r_per[i] != '0) && (rel_cd[i] != '0)) ?
                           rel_cd[i] - TIME_W'(1) : rel_cd[i];
                n_dl[i]  = (rel_dl[i] != DL_MIN) ? rel_dl[i] - DL_W'(1) : rel_dl[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= TCNT_RESET;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < TASKS; i++) begin
                r_cmp[i] <= '0;
                r_per[i] <= '0;
                r_rdl[i] <= '0;
                r_rem[i] <= '0;
                r_cd[i]  <= '0;
                r_dl[i]  <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_task_count <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            for (int i = 0; i < TASKS; i++) begin
                r_cmp[i] <= n_cmp[i];
                r_per[i] <= n_per[i];
                r_rdl[i] <= n_rdl[i];
                r_rem[i] <= n_rem[i];
                r_cd[i]  <= n_cd[i];
                r_dl[i]  <= n_dl[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.action            <= t_action'(s_axis_tuser[0]);
            r_in.slot              <= s_axis_tdata[2:0];
            r_in.compute_time      <= s_axis_tdata[18:3];
            r_in.period            <= s_axis_tdata[34:19];
            r_in.relative_deadline <= s_axis_tdata[50:35];
        end
        if (process) begin
            r_out_idle <= !(is_tick && pick.found);
            r_out_task <= (is_tick && pick.found) ? pick.idx[SLOT_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {{(OUT_DATA_W-SLOT_W){1'b0}}, r_out_task};
    assign m_axis_tuser[0] = r_out_idle;

    a_idle_no_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_idle) |-> (r_out_task == '0))
        else $error("idle result carries a task slot");

    a_load_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_load |=> (r_out_valid && r_out_idle))
        else $error("load item answered with a running task");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

    a_pick_is_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_tick && pick.found) |->
            (ready[pick.idx[SEL_W-1:0]] && active[pick.idx[SEL_W-1:0]]))
        else $error("selected slot is not ready");

endmodule

`default_nettype wire
